>>> sv/slpd_pkg.sv
// Package for the status LED pattern driver: status and operation codes,
// pattern timing, color constants and stream field widths.
// Used by slpd_breath_rom and status_led_pattern_driver_unit; no dependencies.
package slpd_pkg;

  // Status codes; the code is also the priority within a report.
  typedef enum logic [2:0] {
    ST_STOPPED  = 3'd0,
    ST_IDLE     = 3'd1,
    ST_WAITING  = 3'd2,
    ST_RUNNING  = 3'd3,
    ST_THINKING = 3'd4,
    ST_ERROR    = 3'd5
  } status_t;

  // Kind of one input transaction.
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_ENTRY      = 2'd1,
    OP_EMPTY      = 2'd2,
    OP_DISCONNECT = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_STALE_TIMEOUT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MONO_MODE     = 1'd1;
  localparam logic [15:0] STALE_TIMEOUT_RESET = 16'd15000;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  // Report age counter saturates at its all-ones value.
  localparam int unsigned AGE_W = 17;

  // Blink (thinking) and flash (error) timing in milliseconds.
  localparam int unsigned THINK_W         = 10;
  localparam logic [THINK_W-1:0] THINK_LAST = 10'd999;
  localparam logic [THINK_W-1:0] THINK_ON   = 10'd500;
  localparam int unsigned FLASH_W         = 9;
  localparam logic [FLASH_W-1:0] FLASH_LAST = 9'd399;
  localparam logic [FLASH_W-1:0] FLASH_ON   = 9'd200;

  // Fixed colors.
  localparam logic [7:0] LEVEL_FULL = 8'd255;
  localparam logic [7:0] IDLE_RED   = 8'd255;
  localparam logic [7:0] IDLE_GREEN = 8'd193;
  localparam logic [7:0] IDLE_BLUE  = 8'd7;

  // floor(s/3) for s up to 765 as (s * 683) >> 11.
  localparam logic [9:0] MONO_RECIP = 10'd683;
  localparam int unsigned MONO_SHIFT = 11;

  // Fixed-point constants with 60 fraction bits for the breathing table.
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

endpackage

>>> sv/slpd_breath_rom.sv
// Breathing brightness table for one period: folds the phase onto the
// rising half and reads floor(255*(1-cos(2*pi*p/P))/2) with a registered read.
// Depends on slpd_pkg for the fixed-point constants.
module slpd_breath_rom #(
  parameter int PERIOD_MS = 2000,
  localparam int PHASE_W = $clog2(PERIOD_MS)
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [PHASE_W-1:0] phase,
  output logic [7:0]         level
);
  import slpd_pkg::*;

  localparam int DEPTH  = PERIOD_MS / 2 + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [63:0] PI_STEP = PI_Q60 / 64'(PERIOD_MS);
  localparam logic [63:0] PI_REM  = PI_Q60 % 64'(PERIOD_MS);

  typedef logic [7:0] rom_t [DEPTH];

  // Product of two Q60 values, kept in Q60 and truncated to 64 bits.
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // Level at folded phase q: 255 * sin^2(pi*q/P) by a Taylor series.
  function automatic logic [7:0] breath(input int unsigned q);
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  s2;
    logic [127:0] prod;
    if (q == 0) return 8'd0;
    if (2 * q == PERIOD_MS) return LEVEL_FULL;
    x = PI_STEP * 64'(q) + (PI_REM * 64'(q)) / 64'(PERIOD_MS);
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    term = mul_q60(term, x2) / 64'd6;   sum = sum - term;
    term = mul_q60(term, x2) / 64'd20;  sum = sum + term;
    term = mul_q60(term, x2) / 64'd42;  sum = sum - term;
    term = mul_q60(term, x2) / 64'd72;  sum = sum + term;
    term = mul_q60(term, x2) / 64'd110; sum = sum - term;
    term = mul_q60(term, x2) / 64'd156; sum = sum + term;
    term = mul_q60(term, x2) / 64'd210; sum = sum - term;
    term = mul_q60(term, x2) / 64'd272; sum = sum + term;
    term = mul_q60(term, x2) / 64'd342; sum = sum - term;
    term = mul_q60(term, x2) / 64'd420; sum = sum + term;
    term = mul_q60(term, x2) / 64'd506; sum = sum - term;
    term = mul_q60(term, x2) / 64'd600; sum = sum + term;
    term = mul_q60(term, x2) / 64'd702; sum = sum - term;
    term = mul_q60(term, x2) / 64'd812; sum = sum + term;
    if (sum > ONE_Q60) sum = ONE_Q60;
    s2   = mul_q60(sum, sum);
    prod = {64'd0, s2} * 128'd255;
    s2   = prod[123:60];
    return (s2 > 64'd255) ? LEVEL_FULL : s2[7:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < DEPTH; i++) begin
      r[i] = breath(i);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [PHASE_W:0] phase_ext;
  logic [PHASE_W:0] mirror;
  logic [PHASE_W:0] fold;
  logic [ADDR_W-1:0] addr;

  // The waveform is symmetric: fold the phase onto 0 .. P/2.
  always_comb begin
    phase_ext = {1'b0, phase};
    mirror    = (PHASE_W+1)'(PERIOD_MS) - phase_ext;
    fold      = (phase_ext <= mirror) ? phase_ext : mirror;
    addr      = fold[ADDR_W-1:0];
  end

  // Registered table read, taken together with the phase update.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      level <= ROM[addr];
    end
  end

endmodule

>>> sv/status_led_pattern_driver_unit.sv
// Status LED pattern driver top level: input stream, state update, pattern
// and color formation, output register and configuration port.
// Depends on slpd_pkg and slpd_breath_rom.
//
// Usage:
//   The slave stream carries one transaction per event: s_tuser holds the
//   kind (millisecond tick, agent entry, empty report, disconnect), s_tdata
//   the agent status and s_tlast marks the final entry of a report. Every
//   input transaction yields exactly one output transaction with the red,
//   green, blue and mono levels and the status shown after that event.
//   The configuration channel writes the stale timeout (index 0) and mono
//   enable (index 1); always ready; write it only while idle (unchecked).
// Pipeline and throughput:
//   An input that is taken updates the state and reads the breathing
//   tables; the colors are then formed into the output register. One
//   transaction is taken every cycle unless the receiver stalls.
// Reset and stalls:
//   Synchronous reset shows stopped, clears the report timer and all phase
//   counters and restores the register defaults. When the receiver stalls,
//   the output register holds its transaction and one more input is taken
//   into the state stage; after that s_tready stays low until m_tready.
module status_led_pattern_driver_unit #(
  parameter int SHORT_PERIOD_MS = 2000,
  parameter int LONG_PERIOD_MS  = 3000
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream. tdata: agent_status[2:0], zero fill. tuser: op[1:0].
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [slpd_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [slpd_pkg::IN_TUSER_W-1:0]    s_tuser,
  input  logic                               s_tlast,
  // Output stream. tdata: red[7:0], green[15:8], blue[23:16],
  // mono_level[31:24], shown_status[34:32], zero fill.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [slpd_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [slpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [slpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import slpd_pkg::*;

  localparam int SHORT_W = $clog2(SHORT_PERIOD_MS);
  localparam int LONG_W  = $clog2(LONG_PERIOD_MS);

  // Configuration registers.
  logic [15:0] stale_timeout_ms;
  logic        mono_mode;

  // State registers.
  status_t             display_status;
  status_t             best_in_report;
  logic                report_seen;
  logic [AGE_W-1:0]    since_report_ms;
  logic [SHORT_W-1:0]  phase_short;
  logic [LONG_W-1:0]   phase_long;
  logic [THINK_W-1:0]  think_phase;
  logic [FLASH_W-1:0]  flash_phase;
  logic                stage_valid;

  status_t             display_status_next;
  status_t             best_in_report_next;
  logic                report_seen_next;
  logic [AGE_W-1:0]    since_report_ms_next;
  logic [SHORT_W-1:0]  phase_short_next;
  logic [LONG_W-1:0]   phase_long_next;
  logic [THINK_W-1:0]  think_phase_next;
  logic [FLASH_W-1:0]  flash_phase_next;

  logic    accept;
  logic    out_free;
  op_t     op;
  status_t entry_status;

  logic [7:0] level_short;
  logic [7:0] level_long;

  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  mono_level;
  logic [9:0]  rgb_sum;
  logic [19:0] mono_prod;

  // Handshakes: the state stage moves on when the output register frees up.
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !stage_valid || out_free;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign op        = op_t'(s_tuser);

  // Codes above error count as stopped.
  always_comb begin
    if (s_tdata[2:0] > 3'(ST_ERROR)) begin
      entry_status = ST_STOPPED;
    end else begin
      entry_status = status_t'(s_tdata[2:0]);
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_timeout_ms <= STALE_TIMEOUT_RESET;
      mono_mode        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STALE_TIMEOUT: stale_timeout_ms <= cfg_data;
        CFG_MONO_MODE:     mono_mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state for one input transaction.
  always_comb begin
    display_status_next  = display_status;
    best_in_report_next  = best_in_report;
    report_seen_next     = report_seen;
    since_report_ms_next = since_report_ms;
    phase_short_next     = phase_short;
    phase_long_next      = phase_long;
    think_phase_next     = think_phase;
    flash_phase_next     = flash_phase;
    unique case (op)
      OP_TICK: begin
        phase_short_next = (phase_short == SHORT_W'(SHORT_PERIOD_MS - 1)) ?
                           '0 : phase_short + 1'b1;
        phase_long_next  = (phase_long == LONG_W'(LONG_PERIOD_MS - 1)) ?
                           '0 : phase_long + 1'b1;
        think_phase_next = (think_phase == THINK_LAST) ? '0 : think_phase + 1'b1;
        flash_phase_next = (flash_phase == FLASH_LAST) ? '0 : flash_phase + 1'b1;
        if (since_report_ms != '1) begin
          since_report_ms_next = since_report_ms + 1'b1;
        end
      end
      OP_ENTRY: begin
        if (entry_status > best_in_report) begin
          best_in_report_next = entry_status;
        end
        if (s_tlast) begin
          display_status_next  = best_in_report_next;
          best_in_report_next  = ST_STOPPED;
          since_report_ms_next = '0;
          report_seen_next     = 1'b1;
        end
      end
      OP_EMPTY: begin
        display_status_next  = ST_STOPPED;
        best_in_report_next  = ST_STOPPED;
        since_report_ms_next = '0;
        report_seen_next     = 1'b1;
      end
      OP_DISCONNECT: begin
        display_status_next = ST_STOPPED;
        best_in_report_next = ST_STOPPED;
      end
      default: ;
    endcase
    // A stale report forces the display to stopped.
    if (report_seen_next && (since_report_ms_next > {1'b0, stale_timeout_ms})) begin
      display_status_next = ST_STOPPED;
    end
  end

  // State stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      display_status  <= ST_STOPPED;
      best_in_report  <= ST_STOPPED;
      report_seen     <= 1'b0;
      since_report_ms <= '0;
      phase_short     <= '0;
      phase_long      <= '0;
      think_phase     <= '0;
      flash_phase     <= '0;
      stage_valid     <= 1'b0;
    end else begin
      if (accept) begin
        display_status  <= display_status_next;
        best_in_report  <= best_in_report_next;
        report_seen     <= report_seen_next;
        since_report_ms <= since_report_ms_next;
        phase_short     <= phase_short_next;
        phase_long      <= phase_long_next;
        think_phase     <= think_phase_next;
        flash_phase     <= flash_phase_next;
        stage_valid     <= 1'b1;
      end else if (out_free) begin
        stage_valid <= 1'b0;
      end
    end
  end

  // Breathing tables, read at the updated phases.
  slpd_breath_rom #(
    .PERIOD_MS (SHORT_PERIOD_MS)
  ) u_rom_short (
    .clk   (clk),
    .rd_en (accept),
    .phase (phase_short_next),
    .level (level_short)
  );

  slpd_breath_rom #(
    .PERIOD_MS (LONG_PERIOD_MS)
  ) u_rom_long (
    .clk   (clk),
    .rd_en (accept),
    .phase (phase_long_next),
    .level (level_long)
  );

  // Colors for the shown status.
  always_comb begin
    red   = 8'd0;
    green = 8'd0;
    blue  = 8'd0;
    unique case (display_status)
      ST_IDLE: begin
        red   = IDLE_RED;
        green = IDLE_GREEN;
        blue  = IDLE_BLUE;
      end
      ST_WAITING: begin
        red   = LEVEL_FULL;
        green = {1'b0, level_long[7:1]};
      end
      ST_RUNNING:  green = level_short;
      ST_THINKING: blue  = (think_phase < THINK_ON) ? LEVEL_FULL : 8'd0;
      ST_ERROR:    red   = (flash_phase < FLASH_ON) ? LEVEL_FULL : 8'd0;
      default: ;
    endcase
  end

  // Mono level as the average of the three channels in mono mode, else zero.
  always_comb begin
    rgb_sum   = {2'b0, red} + {2'b0, green} + {2'b0, blue};
    mono_prod = {10'd0, rgb_sum} * {10'd0, MONO_RECIP};
    mono_level = mono_mode ? mono_prod[MONO_SHIFT +: 8] : 8'd0;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_valid) begin
      m_tdata <= {5'd0, 3'(display_status), mono_level, blue, green, red};
    end
  end

`ifndef NO_ASSERTIONS
  // Stopped shows all channels dark.
  a_stopped_dark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[34:32] == 3'(ST_STOPPED)) |-> (m_tdata[23:0] == 24'd0))
    else $error("stopped status with a lit channel");

  // Phase counters stay inside their periods.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, phase_short} < (SHORT_W+1)'(SHORT_PERIOD_MS)) &&
    ({1'b0, phase_long} < (LONG_W+1)'(LONG_PERIOD_MS)))
    else $error("breathing phase out of range");

  // Once a report is seen, the flag is never dropped.
  a_report_sticky: assert property (@(posedge clk) disable iff (rst)
    report_seen |=> report_seen)
    else $error("report_seen cleared");

  // Committing a report restarts the age timer.
  a_commit_age: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_ENTRY) && s_tlast |=> (since_report_ms == '0))
    else $error("report commit did not restart the timer");
`endif

endmodule
